/* design/atcr_pkg.sv */
// ----------------------------------------------------------------------------
// AT command recognizer package
// Keyword table, command codes and access kinds shared by the recognizer
// and its port checker.
// ----------------------------------------------------------------------------
package atcr_pkg;

    localparam int KwCount   = 8;
    localparam int KwMaxLen  = 7;

    localparam logic [3:0] NAME_POS_MAX = 4'd15;

    // Command codes; keyword k of the table reports code k + 1.
    localparam logic [3:0] CODE_UNKNOWN = 4'd0;
    localparam logic [3:0] CODE_MAX     = 4'd8;

    // Access kinds.
    localparam logic [2:0] KIND_UNDEF = 3'd0;
    localparam logic [2:0] KIND_BASE  = 3'd1;
    localparam logic [2:0] KIND_READ  = 3'd2;
    localparam logic [2:0] KIND_TEST  = 3'd3;
    localparam logic [2:0] KIND_SET   = 3'd4;

    localparam logic [7:0] CHAR_EQ    = 8'h3D;  // '='
    localparam logic [7:0] CHAR_QUERY = 8'h3F;  // '?'

    // Keyword text, first character in the top byte, short names padded.
    localparam logic [8*KwMaxLen-1:0] KW_TEXT [KwCount] = '{
        "AT+CFUN", {"AT+CBC", 8'h00}, "AT+CLCK", "AT+CPWD",
        "AT+CPIN", "AT+CUSD", "AT+CNUM", "AT+CMEE"
    };

    localparam logic [3:0] KW_LEN [KwCount] = '{
        4'd7, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7
    };

    // Character p of keyword k; positions past the table read as zero.
    function automatic logic [7:0] kw_char(input int k, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        if (int'(p) < KwMaxLen) begin
            c = KW_TEXT[k][8*(KwMaxLen-1-int'(p)) +: 8];
        end
        return c;
    endfunction

    // ASCII lower case letters fold to upper case; all else passes.
    function automatic logic [7:0] fold_upper(input logic [7:0] b);
        logic [7:0] f;
        f = b;
        if (b >= 8'h61 && b <= 8'h7A) begin
            f = b - 8'h20;
        end
        return f;
    endfunction

endpackage

/* design/at_command_recognizer.sv */
// ----------------------------------------------------------------------------
// AT command recognizer
// Classifies one AT command line per run of words into a command code and an
// access kind.
// ----------------------------------------------------------------------------
// One byte of the command line arrives per input word, with tlast on the
// final byte of the line. The block accepts one word per clock cycle while
// the input side does not stall: a word is held in an input register and is
// folded into the line state in the next cycle by a single pass of shallow
// matching logic; a final byte passes from the input register into the result
// register. Exactly one result word leaves per line, when the final byte has
// been processed; it carries the command code (0 for an unknown name, 1 to 8
// for CFUN, CBC, CLCK, CPWD, CPIN, CUSD, CNUM, CMEE with the AT+ prefix,
// matched without regard to case) and the access kind (base, read '?', test
// '=?', set '='; undefined for an unknown name). The input side stalls only
// when a finished result still waits in the output register and another
// final byte needs to leave. After the final byte the line state returns to
// its reset value, ready for the next line.
// ----------------------------------------------------------------------------
module at_command_recognizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] cmd_byte
    input  logic       s_tlast,    // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata     // [3:0] command_code, [6:4] access_kind, [7] zero
);
    import atcr_pkg::*;

    typedef enum logic [1:0] {
        PH_NAME,    // collecting name bytes
        PH_EQ,      // the byte after '=' decides test or set
        PH_DONE     // kind decided, rest of line ignored
    } phase_t;

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg,  in_byte_next;
    logic       in_last_reg,  in_last_next;

    // Line state.
    logic [3:0]       pos_reg,   pos_next;
    logic [KwCount-1:0] hits_reg, hits_next;
    phase_t           phase_reg, phase_next;
    logic [2:0]       kind_reg,  kind_next;

    // Result register.
    logic       out_valid_reg, out_valid_next;
    logic [3:0] out_code_reg,  out_code_next;
    logic [2:0] out_kind_reg,  out_kind_next;

    logic       advance;
    logic [7:0] folded;
    logic [3:0] code;

    // A buffered byte moves on unless it ends a line and the result slot is
    // still occupied by a word the consumer has not taken.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign folded = fold_upper(in_byte_reg);

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_last_next  = in_last_reg;
        if (advance) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
            in_last_next  = s_tlast;
        end
    end

    // Line state update for the buffered byte.
    always_comb begin
        pos_next   = pos_reg;
        hits_next  = hits_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        unique case (phase_reg)
            PH_NAME: begin
                if (pos_reg != 4'd0 && in_byte_reg == CHAR_QUERY) begin
                    kind_next  = KIND_READ;
                    phase_next = PH_DONE;
                end else if (pos_reg != 4'd0 && in_byte_reg == CHAR_EQ) begin
                    kind_next  = KIND_SET;
                    phase_next = PH_EQ;
                end else begin
                    for (int k = 0; k < KwCount; k++) begin
                        hits_next[k] = hits_reg[k] && (pos_reg < KW_LEN[k])
                                       && (kw_char(k, pos_reg[2:0]) == folded);
                    end
                    if (pos_reg != NAME_POS_MAX) begin
                        pos_next = pos_reg + 4'd1;
                    end
                    kind_next = KIND_BASE;
                end
            end
            PH_EQ: begin
                kind_next  = (in_byte_reg == CHAR_QUERY) ? KIND_TEST : KIND_SET;
                phase_next = PH_DONE;
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // The first keyword that still matches over its whole length wins.
    always_comb begin
        code = CODE_UNKNOWN;
        for (int k = KwCount - 1; k >= 0; k--) begin
            if (hits_next[k] && KW_LEN[k] == pos_next) begin
                code = 4'(k + 1);
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        out_kind_next  = out_kind_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
            out_code_next  = code;
            out_kind_next  = (code == CODE_UNKNOWN) ? KIND_UNDEF : kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= 4'd0;
            hits_reg      <= '1;
            phase_reg     <= PH_NAME;
            kind_reg      <= KIND_UNDEF;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                if (in_last_reg) begin
                    // End of line: back to the reset state for the next line.
                    pos_reg   <= 4'd0;
                    hits_reg  <= '1;
                    phase_reg <= PH_NAME;
                    kind_reg  <= KIND_UNDEF;
                end else begin
                    pos_reg   <= pos_next;
                    hits_reg  <= hits_next;
                    phase_reg <= phase_next;
                    kind_reg  <= kind_next;
                end
            end
        end
        in_byte_reg  <= in_byte_next;
        in_last_reg  <= in_last_next;
        out_code_reg <= out_code_next;
        out_kind_reg <= out_kind_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_kind_reg, out_code_reg};

endmodule

/* design/atcr_checker.sv */
// ----------------------------------------------------------------------------
// AT command recognizer port checker
// Watches the ports of the recognizer and checks result words over time.
// ----------------------------------------------------------------------------
module atcr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    import atcr_pkg::*;

    // No result word appears in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // A stalled result word holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // An unknown command carries an undefined kind, a known one a real kind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[3:0] == CODE_UNKNOWN) == (m_tdata[6:4] == KIND_UNDEF)))
        else $error("access kind does not agree with command code");

    // Code and kind stay in their ranges and the pad bit is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] <= CODE_MAX) && (m_tdata[6:4] <= KIND_SET)
                     && !m_tdata[7])
        else $error("result word out of range");

    // A result word only follows a final byte that passed through the input
    // register, or a word that was already waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2)
                            || $past(!s_tready, 1))
        else $error("result word without a final byte");

endmodule

bind at_command_recognizer atcr_checker u_atcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/sv/command_class_checker.sv */
// ----------------------------------------------------------------------------
// Command class checker
// Watches both stream channels of the AT command recognizer, predicts the
// command code and access kind of every command line, and compares each
// result word with the oldest prediction.
// ----------------------------------------------------------------------------
module command_class_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] cmd_byte
    input  logic       s_tlast,    // last_byte
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,    // [3:0] command_code, [6:4] access_kind, [7] zero
    output int         outstanding,
    output int         words_checked,
    output int         mismatches
);
    import atcr_pkg::*;

    typedef enum logic [1:0] {
        PHASE_NAME,
        PHASE_AFTER_EQ,
        PHASE_DECIDED
    } line_phase_t;

    typedef struct packed {
        logic [3:0] code;
        logic [2:0] kind;
    } line_class_t;

    line_class_t expected_classes [$];

    // Line state of the prediction.
    logic [3:0]  name_len;
    logic [7:0]  still_matching;
    line_phase_t phase;
    logic [2:0]  kind_so_far;

    int mismatch_total = 0;
    int checked_total  = 0;

    function automatic string keyword_spelling(input int k);
        string s;
        case (k)
            0:       s = "AT+CFUN";
            1:       s = "AT+CBC";
            2:       s = "AT+CLCK";
            3:       s = "AT+CPWD";
            4:       s = "AT+CPIN";
            5:       s = "AT+CUSD";
            6:       s = "AT+CNUM";
            7:       s = "AT+CMEE";
            default: s = "";
        endcase
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_total++;
        $display("Mismatch at %0t: %s is %0d, expected %0d.", $time, what, got, want);
    endtask

    always @(posedge aclk) begin : watch
        logic [7:0]  folded;
        logic [3:0]  code;
        line_class_t want;
        string       kw;
        int          k;
        if (!aresetn) begin
            name_len       = 4'd0;
            still_matching = 8'hFF;
            phase          = PHASE_NAME;
            kind_so_far    = KIND_UNDEF;
            expected_classes.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_classes.size() == 0) begin
                    report_mismatch("result word with nothing expected", int'(m_tdata), 0);
                end else begin
                    want = expected_classes.pop_front();
                    if (m_tdata[3:0] != want.code) begin
                        report_mismatch("command code", int'(m_tdata[3:0]), int'(want.code));
                    end
                    if (m_tdata[6:4] != want.kind) begin
                        report_mismatch("access kind", int'(m_tdata[6:4]), int'(want.kind));
                    end
                    if (m_tdata[7] != 1'b0) begin
                        report_mismatch("pad bit", int'(m_tdata[7]), 0);
                    end
                    checked_total++;
                end
            end
            if (s_tvalid && s_tready) begin
                if (phase == PHASE_NAME) begin
                    if (name_len != 4'd0 && s_tdata == CHAR_QUERY) begin
                        kind_so_far = KIND_READ;
                        phase       = PHASE_DECIDED;
                    end else if (name_len != 4'd0 && s_tdata == CHAR_EQ) begin
                        kind_so_far = KIND_SET;
                        phase       = PHASE_AFTER_EQ;
                    end else begin
                        // Only ASCII lower case letters fold; everything else
                        // is compared as it stands.
                        folded = s_tdata;
                        if (s_tdata >= "a" && s_tdata <= "z") begin
                            folded = s_tdata - 8'd32;
                        end
                        for (k = 0; k < KwCount; k++) begin
                            kw = keyword_spelling(k);
                            if (int'(name_len) >= kw.len()) begin
                                still_matching[k] = 1'b0;
                            end else if (kw[name_len] != folded) begin
                                still_matching[k] = 1'b0;
                            end
                        end
                        if (name_len != NAME_POS_MAX) begin
                            name_len = name_len + 4'd1;
                        end
                        kind_so_far = KIND_BASE;
                    end
                end else if (phase == PHASE_AFTER_EQ) begin
                    kind_so_far = (s_tdata == CHAR_QUERY) ? KIND_TEST : KIND_SET;
                    phase       = PHASE_DECIDED;
                end
                if (s_tlast) begin
                    code = CODE_UNKNOWN;
                    for (k = 0; k < KwCount; k++) begin
                        kw = keyword_spelling(k);
                        if (code == CODE_UNKNOWN && still_matching[k]
                                && int'(name_len) == kw.len()) begin
                            code = 4'(k + 1);
                        end
                    end
                    want.code = code;
                    want.kind = (code == CODE_UNKNOWN) ? KIND_UNDEF : kind_so_far;
                    expected_classes.push_back(want);
                    name_len       = 4'd0;
                    still_matching = 8'hFF;
                    phase          = PHASE_NAME;
                    kind_so_far    = KIND_UNDEF;
                end
            end
        end
        outstanding   <= expected_classes.size();
        words_checked <= checked_total;
        mismatches    <= mismatch_total;
    end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// AT command recognizer testbench
// Feeds command lines to the recognizer one byte per word, with random gaps
// on both channels, and lets a separate checker predict and compare every
// result word.
// ----------------------------------------------------------------------------
module testbench;
    import atcr_pkg::*;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;     // [7:0] cmd_byte
    logic       s_tlast;     // last_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;     // [3:0] command_code, [6:4] access_kind, [7] zero

    int outstanding;
    int words_checked;
    int mismatches;

    // The command line about to be sent, first byte at the front.
    logic [7:0] line_bytes [$];
    int bytes_sent = 0;
    int lines_sent = 0;

    // While a side is calm it inserts no idle cycles; each side flips its
    // mood now and then, so long back-to-back stretches occur as well.
    bit sender_calm   = 1'b0;
    bit receiver_calm = 1'b0;

    // How a well-formed line ends after its command name.
    typedef enum int {
        ENDING_BASE,
        ENDING_READ,
        ENDING_TEST,
        ENDING_SET
    } line_ending_t;

    at_command_recognizer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    command_class_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .mismatches    (mismatches)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic string keyword_text(input int k);
        string s;
        case (k)
            0:       s = "AT+CFUN";
            1:       s = "AT+CBC";
            2:       s = "AT+CLCK";
            3:       s = "AT+CPWD";
            4:       s = "AT+CPIN";
            5:       s = "AT+CUSD";
            6:       s = "AT+CNUM";
            7:       s = "AT+CMEE";
            default: s = "";
        endcase
        return s;
    endfunction

    function automatic int pick_gap(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 10));
    endfunction

    // Presents one word and returns at the clock edge that accepts it. The
    // valid stays high on return, so a following word with no gap keeps the
    // channel busy without valid ever dropping within a time step.
    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        if ($urandom_range(0, 63) == 0) begin
            sender_calm = !sender_calm;
        end
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_bytes.size(); i++) begin
            send_word(line_bytes[i], i == line_bytes.size() - 1);
        end
        lines_sent++;
    endtask

    task automatic load_text(input string text);
        int i;
        line_bytes.delete();
        for (i = 0; i < text.len(); i++) begin
            line_bytes.push_back(text[i]);
        end
    endtask

    // Drops valid and holds the input side off until every predicted result
    // has come back. The first edge lets the checker take in the word that
    // was accepted last.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // The result side draws a fresh stall for every word it takes.
    initial begin : result_sink
        int gap;
        m_tready <= 1'b0;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 63) == 0) begin
                receiver_calm = !receiver_calm;
            end
            gap = pick_gap(receiver_calm);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        string        kw;
        logic [7:0]   c;
        int           i;
        int           len;
        int           shape;
        int           edit;
        line_ending_t ending;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed lines. Single-byte lines at both ends of the byte range
        // are unknown commands with an undefined kind.
        line_bytes = '{8'hFF};
        send_line();
        line_bytes = '{8'h00};
        send_line();
        // A leading '=' belongs to the name, so the '?' after it makes a
        // read of an unknown name.
        line_bytes = '{CHAR_EQ, CHAR_QUERY};
        send_line();
        // Lower case test access, with a byte after the decision that must
        // be ignored.
        load_text("at+cbc=?x");
        send_line();
        // Set access with nothing after the '='.
        load_text("AT+CMEE=");
        send_line();
        drain();

        // Random lines: mostly keywords with random case, light damage and a
        // random ending; the rest is noise and names too long for any keyword.
        while (bytes_sent < 2000) begin
            line_bytes.delete();
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                len = $urandom_range(1, 20);
                repeat (len) line_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (shape == 1) begin
                // Long enough to saturate the name counter most of the time.
                len = $urandom_range(8, 24);
                repeat (len) line_bytes.push_back(8'("A" + $urandom_range(0, 25)));
            end else begin
                kw = keyword_text($urandom_range(0, 7));
                for (i = 0; i < kw.len(); i++) begin
                    c = kw[i];
                    if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) begin
                        c = c + 8'd32;
                    end
                    line_bytes.push_back(c);
                end
                edit = $urandom_range(0, 9);
                if (edit == 0) begin
                    line_bytes[$urandom_range(0, line_bytes.size() - 1)] =
                        8'($urandom_range(0, 255));
                end else if (edit == 1) begin
                    void'(line_bytes.pop_back());
                end else if (edit == 2) begin
                    line_bytes.push_back(8'("A" + $urandom_range(0, 25)));
                end
                ending = line_ending_t'($urandom_range(0, 3));
                case (ending)
                    ENDING_READ: begin
                        line_bytes.push_back(CHAR_QUERY);
                    end
                    ENDING_TEST: begin
                        line_bytes.push_back(CHAR_EQ);
                        line_bytes.push_back(CHAR_QUERY);
                    end
                    ENDING_SET: begin
                        line_bytes.push_back(CHAR_EQ);
                    end
                    default: begin
                    end
                endcase
                // Trailing parameter bytes after any delimiter.
                if (ending != ENDING_BASE) begin
                    repeat ($urandom_range(0, 4)) begin
                        line_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                end
            end
            send_line();
            // Now and then the input side waits for the block to run empty.
            if (lines_sent % 97 == 0) begin
                drain();
            end
        end

        // Let every result come home before the summary.
        drain();
        repeat (10) @(posedge aclk);

        $display("Sent %0d command bytes in %0d lines: keywords in mixed case with all endings,",
                 bytes_sent, lines_sent);
        $display("damaged and over-long names, and noise; %0d result words compared.",
                 words_checked);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Far beyond the slowest legal run.
    initial begin : watchdog
        #(20 * 400000);
        $display("Timeout: the run did not finish.");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
